// ===== rtl/iprt_pkg.sv =====
// ============================================================================
// iprt_pkg: shared types and codes of the I/O range permission table
// Entry layout, command and status codes, compare flag group.
// ============================================================================
`default_nettype none

package iprt_pkg;

    localparam int unsigned PAGE_SHIFT  = 12;
    localparam int unsigned ADDR_W      = 40;
    localparam int unsigned LEN_W       = 41;
    localparam int unsigned SUM_W       = 42;
    localparam int unsigned SPAGE_W     = ADDR_W - PAGE_SHIFT;
    localparam int unsigned EPAGE_W     = SUM_W - PAGE_SHIFT;
    localparam logic [11:0] PAGE_ROUND  = 12'hFFF;

    localparam logic [1:0] CMD_PERMIT = 2'd0;
    localparam logic [1:0] CMD_DENY   = 2'd1;
    localparam logic [1:0] CMD_CHECK  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERLAP = 2'd1;
    localparam logic [1:0] ST_PARTIAL = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [3:0]         x;
        logic [3:0]         y;
        logic [SPAGE_W-1:0] spage;
        logic [EPAGE_W-1:0] epage;
    } entry_t;

    typedef struct packed {
        logic key_le;    // entry key <= request key
        logic same;      // same shim
        logic ks_lt_ee;  // request start < entry end
        logic ke_gt_es;  // request end > entry start
        logic ks_gt_es;  // request start > entry start
        logic ke_lt_ee;  // request end < entry end
        logic ke_gt_ee;  // request end > entry end
    } cmp_flags_t;

endpackage

`default_nettype wire

// ===== rtl/iprt_cmp.sv =====
// ============================================================================
// iprt_cmp: shared compare unit
// Compares one stored entry against the request key.
// ============================================================================
`default_nettype none

module iprt_cmp (
    input  var iprt_pkg::entry_t     entry,
    input  var iprt_pkg::entry_t     key,
    output var iprt_pkg::cmp_flags_t flags
);

    logic [iprt_pkg::EPAGE_W-1:0] key_s_ext;
    logic [iprt_pkg::EPAGE_W-1:0] ent_s_ext;

    assign key_s_ext = iprt_pkg::EPAGE_W'(key.spage);
    assign ent_s_ext = iprt_pkg::EPAGE_W'(entry.spage);

    always_comb
    begin
        flags.key_le   = {entry.x, entry.y, entry.spage} <= {key.x, key.y, key.spage};
        flags.same     = (entry.x == key.x) && (entry.y == key.y);
        flags.ks_lt_ee = key_s_ext < entry.epage;
        flags.ke_gt_es = key.epage > ent_s_ext;
        flags.ks_gt_es = key.spage > entry.spage;
        flags.ke_lt_ee = key.epage < entry.epage;
        flags.ke_gt_ee = key.epage > entry.epage;
    end

endmodule

`default_nettype wire

// ===== rtl/io_range_permission_table_core.sv =====
// ============================================================================
// io_range_permission_table_core: sorted I/O range permission table
// Binary search, insert and run removal over an entry memory with one read and one write port.
// ============================================================================
// Result time, input transfer to result valid, grows with the search steps (at most 8
//   over 128 entries); permit also with each entry moved, deny also with each extra
//   entry scanned and each entry moved.
// Full permit and no-op command skip the search. Output stalls hold the sequencer in done.
// Throughput: one transfer at a time; in_ready is high only when idle.
// Reset: clears entry count, sequencer and output valid; memory stays as is.
`default_nettype none

module io_range_permission_table_core #(
    parameter int unsigned TABLE_ENTRIES = 128,
    parameter int unsigned ADDRESS_BITS  = 40
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output var  logic        in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [3:0]  shim_x,
    input  wire logic [3:0]  shim_y,
    input  wire logic [39:0] start_address,
    input  wire logic [40:0] byte_length,
    output var  logic        out_valid,
    input  wire logic        out_ready,
    output var  logic [1:0]  status,
    output var  logic        access_allowed
);

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRCH = 4'd1;
    localparam logic [3:0] S_SCMP = 4'd2;
    localparam logic [3:0] S_P_A  = 4'd3;
    localparam logic [3:0] S_P_B  = 4'd4;
    localparam logic [3:0] S_P_SH = 4'd5;
    localparam logic [3:0] S_P_SW = 4'd6;
    localparam logic [3:0] S_D_A  = 4'd7;
    localparam logic [3:0] S_D_B  = 4'd8;
    localparam logic [3:0] S_D_SC = 4'd9;
    localparam logic [3:0] S_D_SW = 4'd10;
    localparam logic [3:0] S_D_EN = 4'd11;
    localparam logic [3:0] S_D_MV = 4'd12;
    localparam logic [3:0] S_D_MW = 4'd13;
    localparam logic [3:0] S_C_A  = 4'd14;
    localparam logic [3:0] S_DONE = 4'd15;

    // Entry memory: one write and one registered read per cycle.
    iprt_pkg::entry_t mem [TABLE_ENTRIES];
    iprt_pkg::entry_t rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    iprt_pkg::entry_t wr_data;

    logic [3:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [CW-1:0]    mid_reg, mid_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    first_reg, first_next;
    logic [iprt_pkg::EPAGE_W-1:0] last_e_reg, last_e_next;
    logic [1:0]       cmd_reg, cmd_next;
    iprt_pkg::entry_t key_reg, key_next;
    logic [1:0]       res_st_reg, res_st_next;
    logic             res_al_reg, res_al_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    logic             allowed_reg, allowed_next;

    iprt_pkg::cmp_flags_t flags;
    logic [CW:0]          mid_sum;
    logic [CW-1:0]        lo_m1;
    logic [CW-1:0]        ptr_m1;
    logic [39:0]          amask;
    logic [39:0]          start_m;
    logic [iprt_pkg::SUM_W-1:0] end_sum;

    iprt_cmp u_cmp (
        .entry (rd_data_reg),
        .key   (key_reg),
        .flags (flags)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Address mask and the one wide end-page add, taken at accept.
    always_comb
    begin
        for (int b = 0; b < 40; b++)
        begin
            amask[b] = (b < int'(ADDRESS_BITS));
        end
        start_m = start_address & amask;
        end_sum = iprt_pkg::SUM_W'(start_m) + iprt_pkg::SUM_W'(byte_length)
                + ((command == iprt_pkg::CMD_CHECK)
                   ? iprt_pkg::SUM_W'(iprt_pkg::PAGE_ROUND) : '0);
    end

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign lo_m1   = lo_reg - CW'(1);
    assign ptr_m1  = ptr_reg - CW'(1);

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign access_allowed = allowed_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        ptr_next       = ptr_reg;
        first_next     = first_reg;
        last_e_next    = last_e_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        res_st_next    = res_st_reg;
        res_al_next    = res_al_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        allowed_next   = allowed_reg;
        rd_addr        = lo_m1[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = ptr_reg[AW-1:0];
        wr_data        = rd_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = command;
                    key_next.x    = shim_x;
                    key_next.y    = shim_y;
                    key_next.spage = start_m[39:iprt_pkg::PAGE_SHIFT];
                    key_next.epage = end_sum[iprt_pkg::SUM_W-1:iprt_pkg::PAGE_SHIFT];
                    lo_next       = '0;
                    hi_next       = count_reg;
                    res_st_next   = iprt_pkg::ST_OK;
                    res_al_next   = 1'b0;
                    if (command == iprt_pkg::CMD_NONE)
                    begin
                        state_next = S_DONE;
                    end
                    else if (command == iprt_pkg::CMD_PERMIT && count_reg == FULL_COUNT)
                    begin
                        res_st_next = iprt_pkg::ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_sum[CW:1];
                    rd_addr    = mid_sum[AW:1];
                    state_next = S_SCMP;
                end
                else
                begin
                    // Fetch the last entry not above the key.
                    rd_addr = lo_m1[AW-1:0];
                    priority case (cmd_reg)
                        iprt_pkg::CMD_PERMIT: state_next = S_P_A;
                        iprt_pkg::CMD_DENY:   state_next = S_D_A;
                        default:              state_next = S_C_A;
                    endcase
                end
            end
            S_SCMP:
            begin
                if (flags.key_le)
                begin
                    lo_next = mid_reg + CW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_P_A:
            begin
                if (lo_reg != '0 && flags.same && flags.ks_lt_ee)
                begin
                    res_st_next = iprt_pkg::ST_OVERLAP;
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_addr    = lo_reg[AW-1:0];
                    state_next = S_P_B;
                end
            end
            S_P_B:
            begin
                if (lo_reg < count_reg && flags.same && flags.ke_gt_es)
                begin
                    res_st_next = iprt_pkg::ST_OVERLAP;
                    state_next  = S_DONE;
                end
                else
                begin
                    ptr_next   = count_reg;
                    state_next = S_P_SH;
                end
            end
            S_P_SH:
            begin
                if (ptr_reg == lo_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = lo_reg[AW-1:0];
                    wr_data    = key_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr    = ptr_m1[AW-1:0];
                    state_next = S_P_SW;
                end
            end
            S_P_SW:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg[AW-1:0];
                ptr_next   = ptr_reg - CW'(1);
                state_next = S_P_SH;
            end
            S_D_A:
            begin
                if (lo_reg != '0 && flags.same && flags.ks_lt_ee)
                begin
                    first_next = lo_m1;
                    if (flags.ks_gt_es || flags.ke_lt_ee)
                    begin
                        res_st_next = iprt_pkg::ST_PARTIAL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        last_e_next = rd_data_reg.epage;
                        ptr_next    = lo_reg;
                        state_next  = S_D_SC;
                    end
                end
                else if (lo_reg >= count_reg)
                begin
                    res_st_next = iprt_pkg::ST_PARTIAL;
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_addr    = lo_reg[AW-1:0];
                    first_next = lo_reg;
                    state_next = S_D_B;
                end
            end
            S_D_B:
            begin
                if (!flags.same || flags.ks_gt_es || flags.ke_lt_ee)
                begin
                    res_st_next = iprt_pkg::ST_PARTIAL;
                    state_next  = S_DONE;
                end
                else
                begin
                    last_e_next = rd_data_reg.epage;
                    ptr_next    = first_reg + CW'(1);
                    state_next  = S_D_SC;
                end
            end
            S_D_SC:
            begin
                if (ptr_reg >= count_reg)
                begin
                    state_next = S_D_EN;
                end
                else
                begin
                    rd_addr    = ptr_reg[AW-1:0];
                    state_next = S_D_SW;
                end
            end
            S_D_SW:
            begin
                if (!flags.same || !flags.ke_gt_es)
                begin
                    state_next = S_D_EN;
                end
                else
                begin
                    last_e_next = rd_data_reg.epage;
                    ptr_next    = ptr_reg + CW'(1);
                    state_next  = S_D_SC;
                end
            end
            S_D_EN:
            begin
                if (key_reg.epage < last_e_reg)
                begin
                    res_st_next = iprt_pkg::ST_PARTIAL;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_D_MV;
                end
            end
            S_D_MV:
            begin
                // ptr is the source, first the destination of the move.
                if (ptr_reg == count_reg)
                begin
                    count_next = first_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr    = ptr_reg[AW-1:0];
                    state_next = S_D_MW;
                end
            end
            S_D_MW:
            begin
                wr_en      = 1'b1;
                wr_addr    = first_reg[AW-1:0];
                first_next = first_reg + CW'(1);
                ptr_next   = ptr_reg + CW'(1);
                state_next = S_D_MV;
            end
            S_C_A:
            begin
                res_al_next = (lo_reg != '0) && flags.same && !flags.ke_gt_ee;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_st_reg;
                    allowed_next   = res_al_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers hold without reset.
    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        ptr_reg     <= ptr_next;
        first_reg   <= first_next;
        last_e_reg  <= last_e_next;
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        res_st_reg  <= res_st_next;
        res_al_reg  <= res_al_next;
        status_reg  <= status_next;
        allowed_reg <= allowed_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above capacity");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P_SH) |-> (count_reg != FULL_COUNT))
        else $error("insert into a full table");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside done state");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        ($past(state_reg) == S_P_SH || $past(state_reg) == S_D_MV))
        else $error("entry count changed outside insert or remove");

endmodule

`default_nettype wire
